@@ src/tqprs_pkg.sv @@
package tqprs_pkg;

  // Store sizes
  localparam int FifoDepth  = 64;
  localparam int StackDepth = 16;
  localparam int TagBits    = 8;

  localparam int FifoAw  = $clog2(FifoDepth);
  localparam int FifoCw  = $clog2(FifoDepth + 1);
  localparam int StackAw = $clog2(StackDepth);
  localparam int StackCw = $clog2(StackDepth + 1);

  // Field widths
  localparam int TagW     = 8;
  localparam int KeyW     = 64;
  localparam int TurnW    = 4;
  localparam int LevelW   = 5;
  localparam int CfgDataW = 5;
  localparam int CntW     = 8;

  localparam logic [TurnW-1:0]  TurnLimitReset  = 4'd3;
  localparam logic [LevelW-1:0] ForceLevelReset = 5'd10;
  localparam logic [KeyW-1:0]   KeyAllOnes      = '1;

  typedef enum logic {
    CfgTurnLimit  = 1'b0,
    CfgForceLevel = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ActAdd      = 1'b0,
    ActDispatch = 1'b1
  } action_e;

  typedef enum logic {
    FromFifo  = 1'b0,
    FromStack = 1'b1
  } from_e;

  // One input word
  typedef struct packed {
    logic            action;
    logic [TagW-1:0] request_tag;
    logic [KeyW-1:0] priority_key;
  } req_t;

  // Result flags; the tag itself comes from the store read
  typedef struct packed {
    logic dispatched;
    logic dispatched_from;
    logic went_priority;
    logic add_dropped;
  } rsp_meta_t;

  typedef struct packed {
    logic               we;
    logic [FifoAw-1:0]  waddr;
    logic [TagBits-1:0] wdata;
    logic               re;
    logic [FifoAw-1:0]  raddr;
  } fifo_cmd_t;

  typedef struct packed {
    logic               we;
    logic [StackAw-1:0] waddr;
    logic [TagBits-1:0] wdata;
    logic               re;
    logic [StackAw-1:0] raddr;
  } stack_cmd_t;

  typedef struct packed {
    logic [FifoCw-1:0]  fifo_fill;
    logic [StackCw-1:0] stack_fill;
    logic               force_flag;
  } status_t;

endpackage

@@ src/tqprs_if.sv @@
// Request channel
interface tqprs_req_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [tqprs_pkg::TagW-1:0] request_tag;
  logic [tqprs_pkg::KeyW-1:0] priority_key;

  modport source (output valid, action, request_tag, priority_key, input ready);
  modport sink   (input valid, action, request_tag, priority_key, output ready);
endinterface

// Result channel
interface tqprs_rsp_if;
  logic                      valid;
  logic                      ready;
  logic                      dispatched;
  logic [tqprs_pkg::TagW-1:0] dispatched_tag;
  logic                      dispatched_from;
  logic                      went_priority;
  logic                      add_dropped;

  modport source (output valid, dispatched, dispatched_tag, dispatched_from,
                  went_priority, add_dropped, input ready);
  modport sink   (input valid, dispatched, dispatched_tag, dispatched_from,
                  went_priority, add_dropped, output ready);
endinterface

@@ src/tqprs_ram.sv @@
module tqprs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/tqprs_ctrl.sv @@
module tqprs_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tqprs_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          fire_i,
  input  tqprs_pkg::req_t               item_i,
  output tqprs_pkg::fifo_cmd_t          fifo_cmd_o,
  output tqprs_pkg::stack_cmd_t         stack_cmd_o,
  output tqprs_pkg::rsp_meta_t          meta_o,
  output tqprs_pkg::status_t            stat_o
);
  import tqprs_pkg::*;

  typedef enum logic [1:0] {
    PathFifo   = 2'd0,
    PathStack  = 2'd1,
    PathForced = 2'd2
  } path_e;

  logic [TurnW-1:0]  turn_limit_q;
  logic [LevelW-1:0] force_level_q;

  logic [FifoAw-1:0]  fifo_head_q, fifo_head_d;
  logic [FifoAw-1:0]  fifo_tail_q, fifo_tail_d;
  logic [FifoCw-1:0]  fifo_fill_q, fifo_fill_d;
  logic [StackCw-1:0] stack_fill_q, stack_fill_d;
  logic [CntW-1:0]    fifo_turns_q, fifo_turns_d;
  logic [CntW-1:0]    stack_turns_q, stack_turns_d;
  logic [CntW-1:0]    forced_turns_q, forced_turns_d;
  logic               force_flag_q, force_flag_d;
  logic [KeyW-1:0]    lowest_key_q, lowest_key_d;

  logic [StackCw-1:0] stack_inc;
  logic [StackCw-1:0] stack_dec;
  logic [TagBits-1:0] tag_keep;
  path_e              path;

  // saturating increment
  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    r = (v == {CntW{1'b1}}) ? v : v + 1'b1;
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_limit_q  <= TurnLimitReset;
      force_level_q <= ForceLevelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTurnLimit:  turn_limit_q  <= cfg_data_i[TurnW-1:0];
        CfgForceLevel: force_level_q <= cfg_data_i[LevelW-1:0];
      endcase
    end
  end

  assign stack_inc = stack_fill_q + 1'b1;
  assign stack_dec = stack_fill_q - 1'b1;
  assign tag_keep  = item_i.request_tag[TagBits-1:0];

  // service choice for a dispatch
  always_comb begin
    if (fifo_fill_q == '0) begin
      path = PathStack;
    end else if (stack_fill_q == '0) begin
      path = PathFifo;
    end else if (force_flag_q) begin
      path = PathForced;
    end else if (fifo_turns_q > turn_limit_q) begin
      path = PathStack;
    end else begin
      path = PathFifo;
    end
  end

  // next state, store commands and result flags
  always_comb begin
    fifo_head_d    = fifo_head_q;
    fifo_tail_d    = fifo_tail_q;
    fifo_fill_d    = fifo_fill_q;
    stack_fill_d   = stack_fill_q;
    fifo_turns_d   = fifo_turns_q;
    stack_turns_d  = stack_turns_q;
    forced_turns_d = forced_turns_q;
    force_flag_d   = force_flag_q;
    lowest_key_d   = lowest_key_q;
    fifo_cmd_o     = '0;
    stack_cmd_o    = '0;
    meta_o         = '0;

    fifo_cmd_o.waddr  = fifo_tail_q;
    fifo_cmd_o.wdata  = tag_keep;
    fifo_cmd_o.raddr  = fifo_head_q;
    stack_cmd_o.waddr = stack_fill_q[StackAw-1:0];
    stack_cmd_o.wdata = tag_keep;
    stack_cmd_o.raddr = stack_dec[StackAw-1:0];

    if (fire_i) begin
      unique case (action_e'(item_i.action))
        ActAdd: begin
          if (item_i.priority_key < lowest_key_q) begin
            meta_o.went_priority = 1'b1;
            if (stack_fill_q == StackCw'(StackDepth)) begin
              meta_o.add_dropped = 1'b1;
            end else begin
              stack_cmd_o.we = 1'b1;
              stack_fill_d   = stack_inc;
              lowest_key_d   = item_i.priority_key;
              if (stack_inc > force_level_q) begin
                force_flag_d = 1'b1;
              end
            end
          end else begin
            if (fifo_fill_q == FifoCw'(FifoDepth)) begin
              meta_o.add_dropped = 1'b1;
            end else begin
              fifo_cmd_o.we = 1'b1;
              fifo_tail_d   = (fifo_tail_q == FifoAw'(FifoDepth - 1)) ? '0
                                                                    : fifo_tail_q + 1'b1;
              fifo_fill_d   = fifo_fill_q + 1'b1;
            end
          end
        end
        ActDispatch: begin
          if (fifo_fill_q != '0 || stack_fill_q != '0) begin
            meta_o.dispatched = 1'b1;
            // turn bookkeeping ahead of the chosen service
            if (fifo_fill_q != '0 && stack_fill_q == '0) begin
              fifo_turns_d = '0;
              lowest_key_d = KeyAllOnes;
            end else if (fifo_fill_q != '0 && !force_flag_q) begin
              fifo_turns_d = sat_inc(fifo_turns_q);
            end
            unique case (path)
              PathForced: begin
                if (forced_turns_q >= turn_limit_q) begin
                  forced_turns_d = '0;
                  force_flag_d   = 1'b0;
                end else begin
                  forced_turns_d = sat_inc(forced_turns_q);
                end
                stack_cmd_o.re         = 1'b1;
                stack_fill_d           = stack_dec;
                meta_o.dispatched_from = FromStack;
              end
              PathStack: begin
                if (stack_turns_q >= turn_limit_q) begin
                  fifo_turns_d  = '0;
                  stack_turns_d = '0;
                end else begin
                  stack_turns_d = sat_inc(stack_turns_q);
                end
                stack_cmd_o.re = 1'b1;
                stack_fill_d   = stack_dec;
                if (stack_dec == '0) begin
                  lowest_key_d = KeyAllOnes;
                end
                meta_o.dispatched_from = FromStack;
              end
              PathFifo: begin
                fifo_cmd_o.re = 1'b1;
                fifo_head_d   = (fifo_head_q == FifoAw'(FifoDepth - 1)) ? '0
                                                                      : fifo_head_q + 1'b1;
                fifo_fill_d   = fifo_fill_q - 1'b1;
                meta_o.dispatched_from = FromFifo;
              end
            endcase
          end
        end
      endcase
    end
  end

  // scheduler state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_head_q    <= '0;
      fifo_tail_q    <= '0;
      fifo_fill_q    <= '0;
      stack_fill_q   <= '0;
      fifo_turns_q   <= '0;
      stack_turns_q  <= '0;
      forced_turns_q <= '0;
      force_flag_q   <= 1'b0;
      lowest_key_q   <= KeyAllOnes;
    end else begin
      fifo_head_q    <= fifo_head_d;
      fifo_tail_q    <= fifo_tail_d;
      fifo_fill_q    <= fifo_fill_d;
      stack_fill_q   <= stack_fill_d;
      fifo_turns_q   <= fifo_turns_d;
      stack_turns_q  <= stack_turns_d;
      forced_turns_q <= forced_turns_d;
      force_flag_q   <= force_flag_d;
      lowest_key_q   <= lowest_key_d;
    end
  end

  assign stat_o.fifo_fill  = fifo_fill_q;
  assign stat_o.stack_fill = stack_fill_q;
  assign stat_o.force_flag = force_flag_q;

endmodule

@@ src/two_queue_priority_request_scheduler.sv @@
// Two-store request scheduler.
// Request channel req_i carries one word per item: action (0 add, 1 dispatch),
// request_tag and a 64-bit priority_key. An add with a key below the lowest
// key recorded goes onto a 16-entry priority stack, any other add onto a 64-entry
// FIFO. A dispatch pops one tag, choosing the store by turn counters, with
// forced stack service once the stack has grown past force_level.
// Result channel rsp_o returns exactly one word per request word, in order.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 turn_limit, 1 force_level); write only while the block is idle.
// An accepted word sits in the input register; the edge that moves it on
// updates the scheduler state together with the store read, and its result
// is valid after that edge.
// Throughput: one word per cycle sustained while rsp_o is not stalled; the
// state update of one word is compare and counter logic plus one store access.
// Reset clears counters and fill levels, sets the lowest key to all ones and
// the registers to 3 and 10; store contents are not cleared and no sweep runs.
// When the receiver stalls, the result register and store read data hold,
// the input register fills, and then req_i.ready drops.
module two_queue_priority_request_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [tqprs_pkg::CfgDataW-1:0] cfg_data_i,
  tqprs_req_if.sink                     req_i,
  tqprs_rsp_if.source                   rsp_o
);
  import tqprs_pkg::*;

  logic       a_valid_q;
  req_t       a_item_q;
  logic       b_valid_q;
  rsp_meta_t  b_meta_q;

  logic       in_fire;
  logic       a_fire;
  logic       b_ready;
  req_t       in_item;

  fifo_cmd_t  fifo_cmd;
  stack_cmd_t stack_cmd;
  rsp_meta_t  meta;
  status_t    stat;

  logic [TagBits-1:0] fifo_rdata;
  logic [TagBits-1:0] stack_rdata;
  logic [TagBits-1:0] tag_sel;

  // pipeline handshake
  assign b_ready     = !b_valid_q || rsp_o.ready;
  assign a_fire      = a_valid_q && b_ready;
  assign req_i.ready = !a_valid_q || b_ready;
  assign in_fire     = req_i.valid && req_i.ready;

  assign in_item.action       = req_i.action;
  assign in_item.request_tag  = req_i.request_tag;
  assign in_item.priority_key = req_i.priority_key;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      a_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_item_q <= in_item;
    end
  end

  tqprs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (a_fire),
    .item_i      (a_item_q),
    .fifo_cmd_o  (fifo_cmd),
    .stack_cmd_o (stack_cmd),
    .meta_o      (meta),
    .stat_o      (stat)
  );

  tqprs_ram #(
    .Width (TagBits),
    .Depth (FifoDepth)
  ) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_cmd.we),
    .waddr_i (fifo_cmd.waddr),
    .wdata_i (fifo_cmd.wdata),
    .re_i    (fifo_cmd.re),
    .raddr_i (fifo_cmd.raddr),
    .rdata_o (fifo_rdata)
  );

  tqprs_ram #(
    .Width (TagBits),
    .Depth (StackDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stack_cmd.we),
    .waddr_i (stack_cmd.waddr),
    .wdata_i (stack_cmd.wdata),
    .re_i    (stack_cmd.re),
    .raddr_i (stack_cmd.raddr),
    .rdata_o (stack_rdata)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_meta_q <= meta;
    end
  end

  // result word
  assign tag_sel = (b_meta_q.dispatched_from == FromStack) ? stack_rdata : fifo_rdata;

  assign rsp_o.valid           = b_valid_q;
  assign rsp_o.dispatched      = b_meta_q.dispatched;
  assign rsp_o.dispatched_tag  = b_meta_q.dispatched ? TagW'(tag_sel) : '0;
  assign rsp_o.dispatched_from = b_meta_q.dispatched_from;
  assign rsp_o.went_priority   = b_meta_q.went_priority;
  assign rsp_o.add_dropped     = b_meta_q.add_dropped;

`ifndef SYNTHESIS
  // fill levels stay within the store sizes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.fifo_fill <= FifoCw'(FifoDepth))
    else $error("fifo fill beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.stack_fill <= StackCw'(StackDepth))
    else $error("stack fill beyond depth");

  // a dispatch with both stores empty returns nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fire && a_item_q.action == ActDispatch && stat.fifo_fill == '0 &&
    stat.stack_fill == '0 |=> rsp_o.valid && !rsp_o.dispatched)
    else $error("dispatch from empty stores");

  // an add never reports a dispatch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fire && a_item_q.action == ActAdd |=> rsp_o.valid && !rsp_o.dispatched &&
    rsp_o.dispatched_tag == '0)
    else $error("add reported a dispatch");
`endif

endmodule
